// ----- sv/spq_pkg.sv -----
// ----------------------------------------------------------------------------
// Scale pitch quantizer package
// Shared widths, constants, command and status codes, and control types.
// ----------------------------------------------------------------------------
package spq_pkg;

  // Number of interval slots in the scale table.
  localparam int TABLE_DEPTH = 32;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // Pitch format: 1/64 cent units, one octave is 76800 units.
  localparam int PITCH_W      = 24;
  localparam int FRAC_W       = 17;
  localparam int DIST_W       = 18;
  localparam int OCT_W        = 8;
  localparam int SUM_W        = 26;
  localparam int OCTAVE_UNITS = 76800;

  // Floor division by one octave. The biased value is always positive:
  // bias = 110 octaves - 2^23. The quotient is ((w >> 10) * M) >> 22 with
  // M = ceil(2^22 / 75), which is exact for every biased value in range.
  localparam int FOLD_W      = 25;
  localparam int FOLD_BIAS   = 59392;
  localparam int OCT_BIAS    = 110;
  localparam int PRE_SHIFT   = 10;
  localparam int X_W         = FOLD_W - PRE_SHIFT;
  localparam int RECIP_MULT  = 55925;
  localparam int RECIP_W     = 16;
  localparam int RECIP_SHIFT = 22;
  localparam int PROD_W      = 30;
  localparam int QUO_W       = 8;

  localparam logic signed [SUM_W-1:0] SUM_MAX = 26'sd8388607;
  localparam logic signed [SUM_W-1:0] SUM_MIN = -26'sd8388608;

  localparam logic signed [1:0] SHIFT_DN   = -2'sd1;
  localparam logic signed [1:0] SHIFT_NONE = 2'sd0;
  localparam logic signed [1:0] SHIFT_UP   = 2'sd1;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_QUANT = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    STAT_QUANT   = 3'd0,
    STAT_PASS    = 3'd1,
    STAT_ADDED   = 3'd2,
    STAT_DUP     = 3'd3,
    STAT_FULL    = 3'd4,
    STAT_CLEARED = 3'd5,
    STAT_SAT     = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_ROTATE,
    CELL_INSERT
  } cell_op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FOLD,
    S_SEED,
    S_SCAN,
    S_INSERT,
    S_SCALE,
    S_SAT,
    S_EMIT
  } fsm_t;

  // Control word broadcast to every cell of the table.
  typedef struct packed {
    cell_op_t              op;
    logic [IDX_W-1:0]      pos;
    logic [FRAC_W-1:0]     value;
  } cell_ctrl_t;

endpackage

// ----- sv/spq_ifs.sv -----
// ----------------------------------------------------------------------------
// Scale pitch quantizer channels
// Valid/ready request channels for incoming commands and outgoing results.
// ----------------------------------------------------------------------------
interface spq_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic signed [23:0] interval_value;
  logic signed [23:0] voltage_in;

  modport source (output valid, cmd, interval_value, voltage_in, input ready);
  modport sink   (input valid, cmd, interval_value, voltage_in, output ready);
endinterface

interface spq_out_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] voltage_out;
  logic [4:0]         chosen_entry;
  logic signed [1:0]  octave_shift;
  logic [2:0]         status;
  logic [5:0]         entry_count;

  modport source (output valid, voltage_out, chosen_entry, octave_shift, status,
                  entry_count, input ready);
  modport sink   (input valid, voltage_out, chosen_entry, octave_shift, status,
                  entry_count, output ready);
endinterface

// ----- sv/spq_cell.sv -----
// ----------------------------------------------------------------------------
// Scale table cell
// Holds one interval; rotates toward cell zero or shifts up on insertion.
// ----------------------------------------------------------------------------
module spq_cell
  import spq_pkg::*;
(
  input  logic              clk,
  input  cell_ctrl_t        ctrl,
  input  logic [IDX_W-1:0]  cell_idx,
  input  logic [FRAC_W-1:0] from_left,
  input  logic [FRAC_W-1:0] from_right,
  output logic [FRAC_W-1:0] entry
);

  logic [FRAC_W-1:0] entry_r;
  logic [FRAC_W-1:0] entry_nxt;

  always_comb begin
    entry_nxt = entry_r;
    case (ctrl.op)
      CELL_ROTATE: entry_nxt = from_right;
      CELL_INSERT: begin
        if (cell_idx == ctrl.pos) begin
          entry_nxt = ctrl.value;
        end else if (cell_idx > ctrl.pos) begin
          entry_nxt = from_left;
        end
      end
      default: entry_nxt = entry_r;
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule

// ----- sv/spq_fold.sv -----
// ----------------------------------------------------------------------------
// Octave fold unit
// Two-stage floor division of a signed pitch by one octave.
// ----------------------------------------------------------------------------
module spq_fold
  import spq_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic signed [PITCH_W-1:0] value,
  output logic                     done,
  output logic signed [OCT_W-1:0]  oct,
  output logic [FRAC_W-1:0]        frac
);

  logic [FOLD_W-1:0]       w;
  logic [PROD_W-1:0]       prod;
  logic [FOLD_W-1:0]       w_r;
  logic [PROD_W-1:0]       prod_r;
  logic                    s1_r;
  logic                    done_r;
  logic [QUO_W-1:0]        quo;
  logic [FOLD_W-1:0]       rem;
  logic signed [OCT_W-1:0] oct_r;
  logic [FRAC_W-1:0]       frac_r;

  // Flipping the sign bit gives the value plus 2^23 as an unsigned number;
  // adding the rest of the bias makes it a whole number of octaves above the
  // input. The biased value never goes negative, so plain unsigned math is
  // exact.
  assign w    = FOLD_W'({~value[PITCH_W-1], value[PITCH_W-2:0]}) + FOLD_W'(FOLD_BIAS);
  assign prod = PROD_W'(w[FOLD_W-1:PRE_SHIFT] * RECIP_W'(RECIP_MULT));
  assign quo  = prod_r[RECIP_SHIFT +: QUO_W];
  assign rem  = w_r - FOLD_W'(FOLD_W'(quo) * FOLD_W'(OCTAVE_UNITS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      s1_r   <= start;
      done_r <= s1_r;
    end
  end

  always_ff @(posedge clk) begin
    w_r    <= w;
    prod_r <= prod;
    if (s1_r) begin
      oct_r  <= $signed(quo) - OCT_W'(OCT_BIAS);
      frac_r <= rem[FRAC_W-1:0];
    end
  end

  assign done = done_r;
  assign oct  = oct_r;
  assign frac = frac_r;

endmodule

// ----- sv/scale_pitch_quantizer.sv -----
// ----------------------------------------------------------------------------
// Scale pitch quantizer
// Snaps a 1 V/octave pitch to the nearest interval of a programmable scale.
// ----------------------------------------------------------------------------
//
//   Channel   Dir   Handshake      Payload
//   in_ch     in    valid/ready    cmd, interval_value, voltage_in
//   out_ch    out   valid/ready    voltage_out, chosen_entry, octave_shift,
//                                  status, entry_count
//
// A clear, or a quantize request on an empty table, goes from acceptance
// straight to the emit state. An add runs through fold, seed (only into an
// empty table, to seed unison), scan, insert and emit; a quantize through
// fold, scan, scale, saturate and emit. In the scan the row of cells rotates
// one place per cycle through the single distance evaluator at cell zero, a
// full turn per scan, so the table ends in its original order.
// Reset is synchronous and active low; it empties the table. The contents of
// the cells are not cleared. A new request is taken while a finished result
// still waits in the output register; a stalled output only holds the block
// in its final state until the register frees up.
// ----------------------------------------------------------------------------
module scale_pitch_quantizer
  import spq_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  spq_in_if.sink     in_ch,
  spq_out_if.source  out_ch
);

  localparam logic [IDX_W-1:0] SCAN_LAST = IDX_W'(TABLE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(TABLE_DEPTH);

  fsm_t state_r;
  fsm_t state_nxt;

  // Table row.
  cell_ctrl_t        cell_ctrl;
  logic [FRAC_W-1:0] cell_val [TABLE_DEPTH];

  // Fold unit.
  logic                     fold_start;
  logic signed [PITCH_W-1:0] fold_value;
  logic                     fold_done;
  logic signed [OCT_W-1:0]  fold_oct;
  logic [FRAC_W-1:0]        fold_frac;

  // Control and scan state.
  logic [CNT_W-1:0]  count_r,   count_nxt;
  logic              is_add_r,  is_add_nxt;
  logic              seeded_r,  seeded_nxt;
  logic [IDX_W-1:0]  scan_r,    scan_nxt;
  logic              found_r,   found_nxt;
  logic              dup_r,     dup_nxt;
  logic [IDX_W-1:0]  pos_r,     pos_nxt;
  logic              bvalid_r,  bvalid_nxt;
  logic [DIST_W-1:0] bdist_r,   bdist_nxt;
  logic [IDX_W-1:0]  bidx_r,    bidx_nxt;
  logic signed [1:0] bshift_r,  bshift_nxt;
  logic [FRAC_W-1:0] bval_r,    bval_nxt;
  logic signed [SUM_W-1:0] base_r, base_nxt;

  // Staged result.
  logic signed [PITCH_W-1:0] res_vout_r,   res_vout_nxt;
  logic [IDX_W-1:0]          res_chosen_r, res_chosen_nxt;
  logic signed [1:0]         res_shift_r,  res_shift_nxt;
  status_t                   res_status_r, res_status_nxt;

  // Output register.
  logic                      out_valid_r,  out_valid_nxt;
  logic signed [PITCH_W-1:0] out_vout_r,   out_vout_nxt;
  logic [4:0]                out_chosen_r, out_chosen_nxt;
  logic signed [1:0]         out_shift_r,  out_shift_nxt;
  logic [2:0]                out_status_r, out_status_nxt;
  logic [5:0]                out_count_r,  out_count_nxt;

  // Evaluator signals.
  logic                in_tab;
  logic [FRAC_W-1:0]   head;
  logic [DIST_W:0]     f19, e19, u19;
  logic [DIST_W-1:0]   d_dn, d_same, d_up;
  logic [DIST_W-1:0]   loc_dist;
  logic signed [1:0]   loc_shift;
  logic [IDX_W-1:0]    ins_pos;
  logic signed [8:0]   sh_oct;
  logic signed [SUM_W-1:0] sum;
  logic                slot_free;
  logic                accept;

  // --------------------------------------------------------------------------
  // Row of cells. Rotation moves every entry one place toward cell zero,
  // with cell zero wrapping to the far end; insertion shifts entries at and
  // above the insert point one place up.
  // --------------------------------------------------------------------------
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    spq_cell u_cell (
      .clk        (clk),
      .ctrl       (cell_ctrl),
      .cell_idx   (IDX_W'(i)),
      .from_left  (cell_val[(i + TABLE_DEPTH - 1) % TABLE_DEPTH]),
      .from_right (cell_val[(i + 1) % TABLE_DEPTH]),
      .entry      (cell_val[i])
    );
  end

  spq_fold u_fold (
    .clk   (clk),
    .rst_n (rst_n),
    .start (fold_start),
    .value (fold_value),
    .done  (fold_done),
    .oct   (fold_oct),
    .frac  (fold_frac)
  );

  assign accept     = in_ch.valid && in_ch.ready;
  assign slot_free  = !out_valid_r || out_ch.ready;
  // Only adds and quantizes start the fold; a stray done pulse from a quantize
  // on an empty table ends before the next request can reach the fold wait.
  assign fold_start = accept && (in_ch.cmd == CMD_ADD || in_ch.cmd == CMD_QUANT);
  assign fold_value = (in_ch.cmd == CMD_ADD) ? in_ch.interval_value : in_ch.voltage_in;

  // --------------------------------------------------------------------------
  // Distance evaluator at the head of the row. The entry is tried one octave
  // down, in the same octave and one octave up; the first of equal distances
  // wins, matching the order in which candidates are considered.
  // --------------------------------------------------------------------------
  assign head   = cell_val[0];
  assign in_tab = CNT_W'(scan_r) < count_r;
  assign f19    = (DIST_W + 1)'(fold_frac);
  assign e19    = (DIST_W + 1)'(head);
  assign u19    = (DIST_W + 1)'(OCTAVE_UNITS);
  assign d_dn   = DIST_W'(f19 + u19 - e19);
  assign d_same = (f19 >= e19) ? DIST_W'(f19 - e19) : DIST_W'(e19 - f19);
  assign d_up   = DIST_W'(e19 + u19 - f19);

  always_comb begin
    if (d_dn <= d_same && d_dn <= d_up) begin
      loc_dist  = d_dn;
      loc_shift = SHIFT_DN;
    end else if (d_same <= d_up) begin
      loc_dist  = d_same;
      loc_shift = SHIFT_NONE;
    end else begin
      loc_dist  = d_up;
      loc_shift = SHIFT_UP;
    end
  end

  // An interval not below any entry lands just past the last one.
  assign ins_pos = found_r ? pos_r : IDX_W'(count_r);
  assign sh_oct  = 9'(fold_oct) + 9'(bshift_r);
  assign sum     = base_r + $signed(SUM_W'(bval_r));

  // --------------------------------------------------------------------------
  // Next state.
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          case (in_ch.cmd)
            CMD_CLEAR: state_nxt = S_EMIT;
            CMD_ADD:   state_nxt = S_FOLD;
            CMD_QUANT: state_nxt = (count_r == '0) ? S_EMIT : S_FOLD;
            default:   state_nxt = S_IDLE;
          endcase
        end
      end
      S_FOLD: begin
        if (fold_done) begin
          state_nxt = (is_add_r && count_r == '0) ? S_SEED : S_SCAN;
        end
      end
      S_SEED: state_nxt = S_SCAN;
      S_SCAN: begin
        if (scan_r == SCAN_LAST) begin
          state_nxt = is_add_r ? S_INSERT : S_SCALE;
        end
      end
      S_INSERT: state_nxt = S_EMIT;
      S_SCALE:  state_nxt = S_SAT;
      S_SAT:    state_nxt = S_EMIT;
      S_EMIT: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Outputs and datapath.
  // --------------------------------------------------------------------------
  always_comb begin
    in_ch.ready     = (state_r == S_IDLE);
    cell_ctrl.op    = CELL_HOLD;
    cell_ctrl.pos   = '0;
    cell_ctrl.value = '0;

    count_nxt      = count_r;
    is_add_nxt     = is_add_r;
    seeded_nxt     = seeded_r;
    scan_nxt       = scan_r;
    found_nxt      = found_r;
    dup_nxt        = dup_r;
    pos_nxt        = pos_r;
    bvalid_nxt     = bvalid_r;
    bdist_nxt      = bdist_r;
    bidx_nxt       = bidx_r;
    bshift_nxt     = bshift_r;
    bval_nxt       = bval_r;
    base_nxt       = base_r;
    res_vout_nxt   = res_vout_r;
    res_chosen_nxt = res_chosen_r;
    res_shift_nxt  = res_shift_r;
    res_status_nxt = res_status_r;

    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_vout_nxt   = out_vout_r;
    out_chosen_nxt = out_chosen_r;
    out_shift_nxt  = out_shift_r;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          is_add_nxt     = (in_ch.cmd == CMD_ADD);
          seeded_nxt     = 1'b0;
          scan_nxt       = '0;
          found_nxt      = 1'b0;
          dup_nxt        = 1'b0;
          pos_nxt        = '0;
          bvalid_nxt     = 1'b0;
          res_vout_nxt   = '0;
          res_chosen_nxt = '0;
          res_shift_nxt  = SHIFT_NONE;
          if (in_ch.cmd == CMD_CLEAR) begin
            count_nxt      = '0;
            res_status_nxt = STAT_CLEARED;
          end else if (in_ch.cmd == CMD_QUANT && count_r == '0) begin
            res_vout_nxt   = in_ch.voltage_in;
            res_status_nxt = STAT_PASS;
          end
        end
      end
      S_SEED: begin
        // Unison goes in first whenever an add finds the table empty.
        cell_ctrl.op    = CELL_INSERT;
        cell_ctrl.pos   = '0;
        cell_ctrl.value = '0;
        count_nxt       = CNT_W'(1);
        seeded_nxt      = 1'b1;
      end
      S_SCAN: begin
        cell_ctrl.op = CELL_ROTATE;
        scan_nxt     = scan_r + 1'b1;
        if (in_tab) begin
          if (is_add_r) begin
            if (!found_r && head >= fold_frac) begin
              found_nxt = 1'b1;
              pos_nxt   = scan_r;
              dup_nxt   = (head == fold_frac);
            end
          end else if (!bvalid_r || loc_dist < bdist_r) begin
            bvalid_nxt = 1'b1;
            bdist_nxt  = loc_dist;
            bidx_nxt   = scan_r;
            bshift_nxt = loc_shift;
            bval_nxt   = head;
          end
        end
      end
      S_INSERT: begin
        if (found_r && dup_r) begin
          // A zero interval on the first add matches the seeded unison.
          res_status_nxt = seeded_r ? STAT_ADDED : STAT_DUP;
          res_chosen_nxt = pos_r;
        end else if (count_r == CNT_FULL) begin
          res_status_nxt = STAT_FULL;
          res_chosen_nxt = '0;
        end else begin
          cell_ctrl.op    = CELL_INSERT;
          cell_ctrl.pos   = ins_pos;
          cell_ctrl.value = fold_frac;
          count_nxt       = count_r + 1'b1;
          res_status_nxt  = STAT_ADDED;
          res_chosen_nxt  = ins_pos;
        end
      end
      S_SCALE: begin
        base_nxt = SUM_W'(sh_oct) * SUM_W'(OCTAVE_UNITS);
      end
      S_SAT: begin
        res_chosen_nxt = bidx_r;
        res_shift_nxt  = bshift_r;
        if (sum > SUM_MAX) begin
          res_vout_nxt   = PITCH_W'(SUM_MAX);
          res_status_nxt = STAT_SAT;
        end else if (sum < SUM_MIN) begin
          res_vout_nxt   = PITCH_W'(SUM_MIN);
          res_status_nxt = STAT_SAT;
        end else begin
          res_vout_nxt   = PITCH_W'(sum);
          res_status_nxt = STAT_QUANT;
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_vout_nxt   = res_vout_r;
          out_chosen_nxt = 5'(res_chosen_r);
          out_shift_nxt  = res_shift_r;
          out_status_nxt = res_status_r;
          out_count_nxt  = 6'(count_r);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      is_add_r    <= 1'b0;
      seeded_r    <= 1'b0;
      scan_r      <= '0;
      found_r     <= 1'b0;
      dup_r       <= 1'b0;
      bvalid_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      is_add_r    <= is_add_nxt;
      seeded_r    <= seeded_nxt;
      scan_r      <= scan_nxt;
      found_r     <= found_nxt;
      dup_r       <= dup_nxt;
      bvalid_r    <= bvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r        <= pos_nxt;
    bdist_r      <= bdist_nxt;
    bidx_r       <= bidx_nxt;
    bshift_r     <= bshift_nxt;
    bval_r       <= bval_nxt;
    base_r       <= base_nxt;
    res_vout_r   <= res_vout_nxt;
    res_chosen_r <= res_chosen_nxt;
    res_shift_r  <= res_shift_nxt;
    res_status_r <= res_status_nxt;
    out_vout_r   <= out_vout_nxt;
    out_chosen_r <= out_chosen_nxt;
    out_shift_r  <= out_shift_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.voltage_out  = out_vout_r;
  assign out_ch.chosen_entry = out_chosen_r;
  assign out_ch.octave_shift = out_shift_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.entry_count  = out_count_r;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_FULL)
    else $error("table count beyond depth");

  a_full_turn: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && state_nxt != S_SCAN) |-> scan_r == SCAN_LAST)
    else $error("scan left before the table made a full turn");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != $past(count_r)) |->
      (count_r == '0 || count_r == $past(count_r) + 1'b1))
    else $error("table count moved by other than one or a clear");

  a_emit_only: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_EMIT)
    else $error("result presented outside the emit state");
`endif

endmodule

// ----- test/scale_pitch_quantizer_tb.sv -----
// ----------------------------------------------------------------------------
// Scale pitch quantizer testbench
// Drives clear, add, quantize and unused-code requests through the valid/ready
// input channel and checks every result against a cycle-free scoreboard model
// of the interval table, across several source and sink idling patterns.
// ----------------------------------------------------------------------------
module scale_pitch_quantizer_tb;
  import spq_pkg::*;

  // The command encoding leaves one code unused; the block drops it silently.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam int PITCH_MAX    = 8388607;
  localparam int PITCH_MIN    = -8388608;
  localparam int HOLD_CYCLES  = 400;
  localparam int SETTLE_CYCLES = TABLE_DEPTH + 12;
  localparam int PHASE_ITEMS  = 245;
  localparam longint TIMEOUT  = 64'd6000000;

  // One pending input request, exactly as it goes onto the channel.
  typedef struct {
    logic [1:0]         cmd;
    logic signed [23:0] interval;
    logic signed [23:0] voltage;
  } scale_request_t;

  // One predicted result, field for field as the output channel carries it.
  typedef struct {
    logic signed [23:0] pitch;
    logic [4:0]         entry;
    logic signed [1:0]  shift;
    status_t            status;
    logic [5:0]         count;
  } scale_response_t;

  logic clk;
  logic rst_n;

  spq_in_if  in_ch ();
  spq_out_if out_ch ();

  scale_pitch_quantizer uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Requests waiting to be offered, and results waiting to be seen.
  scale_request_t  request_queue[$];
  scale_response_t awaited_responses[$];

  // Scoreboard copy of the interval table. Only entries below note_count
  // are meaningful, exactly as in the block.
  int scale_table[TABLE_DEPTH];
  int note_count;

  // Folded intervals the generator has added in the current scale, used to
  // aim quantize voltages at and between real table entries.
  int scale_notes[$];
  int corner_pitch[6] = '{0, 76800, -1, 8388607, -8388608, 76799};

  // Traffic shaping knobs, set per phase by the main sequence.
  int src_idle_pct;
  int snk_stall_pct;
  logic hold_go;
  int hold_left;
  logic req_taken;

  int phase_count;
  int mismatches;
  int ignored_count;
  int status_tally[8];
  scale_response_t want;

  // --------------------------------------------------------------------------
  // Clock: period of 12 time units.
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog: a correct run finishes far inside this window, even with the
  // heaviest idling and the long receiver hold-off.
  initial begin
    #(TIMEOUT);
    $display("scale_pitch_quantizer test failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Helpers for the pitch arithmetic.
  // --------------------------------------------------------------------------

  // Reduce any pitch into a single octave, 0 .. OCTAVE_UNITS-1. A negative
  // remainder is moved up by one octave so that e.g. -1 becomes 76799.
  function automatic int fold_octave(int x);
    int m;
    m = x % OCTAVE_UNITS;
    if (m < 0) m += OCTAVE_UNITS;
    return m;
  endfunction

  function automatic int clamp_pitch(longint x);
    if (x > PITCH_MAX) return PITCH_MAX;
    if (x < PITCH_MIN) return PITCH_MIN;
    return int'(x);
  endfunction

  // A uniformly random 24-bit signed pitch, sign-extended to int.
  function automatic int rand_pitch();
    logic signed [23:0] r;
    r = 24'($urandom());
    return int'(r);
  endfunction

  // --------------------------------------------------------------------------
  // Scoreboard model. Called once per accepted request, in acceptance order,
  // it updates the table copy and queues the result the block must return.
  // --------------------------------------------------------------------------
  task automatic compute_response(logic [1:0] cmd, logic signed [23:0] ivl,
                                  logic signed [23:0] vin);
    scale_response_t r;
    int folded, pos, v, oct, frac, cand, gap, best, chosen, shift;
    bit seeded;
    longint pitch;
    if (cmd == CMD_UNUSED) begin
      // Unused code: no state change and no result at all.
      ignored_count++;
      return;
    end
    r.pitch  = '0;
    r.entry  = '0;
    r.shift  = SHIFT_NONE;
    r.status = STAT_QUANT;
    case (cmd)
      CMD_CLEAR: begin
        note_count = 0;
        r.status   = STAT_CLEARED;
      end
      CMD_ADD: begin
        folded = fold_octave(int'(ivl));
        // The first add into an empty table seeds unison at slot zero.
        seeded = (note_count == 0);
        if (seeded) begin
          scale_table[0] = 0;
          note_count     = 1;
        end
        if (seeded && folded == 0) begin
          r.status = STAT_ADDED;
        end else begin
          pos = 0;
          while (pos < note_count && scale_table[pos] < folded) pos++;
          if (pos < note_count && scale_table[pos] == folded) begin
            // A duplicate is reported even when the table is full.
            r.status = STAT_DUP;
            r.entry  = 5'(pos);
          end else if (note_count >= TABLE_DEPTH) begin
            r.status = STAT_FULL;
          end else begin
            for (int k = note_count; k > pos; k--) scale_table[k] = scale_table[k-1];
            scale_table[pos] = folded;
            note_count++;
            r.status = STAT_ADDED;
            r.entry  = 5'(pos);
          end
        end
      end
      default: begin
        v = int'(vin);
        if (note_count == 0) begin
          // Empty scale: the pitch goes through untouched.
          r.pitch  = vin;
          r.status = STAT_PASS;
        end else begin
          // Floor division into whole octaves and a non-negative fraction.
          oct = v / OCTAVE_UNITS;
          if ((v % OCTAVE_UNITS) != 0 && v < 0) oct--;
          frac = v - oct * OCTAVE_UNITS;
          // Every entry is tried one octave down, in place and one octave
          // up. Only a strictly closer candidate displaces the current best,
          // so on a tie the lowest entry, lowest octave wins.
          best   = -1;
          chosen = 0;
          shift  = 0;
          for (int i = 0; i < note_count; i++) begin
            for (int d = -1; d <= 1; d++) begin
              cand = scale_table[i] + d * OCTAVE_UNITS;
              gap  = frac - cand;
              if (gap < 0) gap = -gap;
              if (best < 0 || gap < best) begin
                best   = gap;
                chosen = i;
                shift  = d;
              end
            end
          end
          pitch = longint'(oct + shift) * OCTAVE_UNITS + scale_table[chosen];
          r.entry = 5'(chosen);
          r.shift = 2'(shift);
          if (pitch > PITCH_MAX || pitch < PITCH_MIN) r.status = STAT_SAT;
          r.pitch = 24'(clamp_pitch(pitch));
        end
      end
    endcase
    r.count = 6'(note_count);
    status_tally[r.status]++;
    awaited_responses.insert(awaited_responses.size(), r);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus generation.
  // --------------------------------------------------------------------------
  task automatic queue_request(logic [1:0] cmd, int ivl, int vin);
    scale_request_t q;
    q.cmd      = cmd;
    q.interval = 24'(ivl);
    q.voltage  = 24'(vin);
    request_queue.insert(request_queue.size(), q);
    if (cmd != CMD_UNUSED) phase_count++;
  endtask

  // One musical session: usually a clear, a run of adds that builds a scale,
  // then quantize requests aimed at, between and away from its notes. Now and
  // then an unused code or a fully random request is mixed in as noise.
  task automatic gen_scale_session();
    int n_add, n_quant, k, oct, semis, a, b, ofs;
    bit big;
    longint target;
    if ($urandom_range(0, 99) < 85) begin
      queue_request(CMD_CLEAR, rand_pitch(), rand_pitch());
      scale_notes.delete();
    end
    // About one session in ten tries to overfill the table.
    big   = ($urandom_range(0, 9) == 0);
    n_add = big ? $urandom_range(36, 45) : $urandom_range(1, 10);
    repeat (n_add) begin
      oct   = $urandom_range(0, 200);
      oct   = oct - 100;
      semis = $urandom_range(0, 11);
      k     = big ? (($urandom_range(0, 6) == 0) ? 4 : 5) : $urandom_range(0, 6);
      case (k)
        0, 1, 2: target = longint'(semis) * 6400 + longint'(oct) * OCTAVE_UNITS;
        3:       target = rand_pitch();
        4: begin
          if (scale_notes.size() != 0) begin
            a      = $urandom_range(0, scale_notes.size() - 1);
            target = scale_notes[a] + longint'(oct) * OCTAVE_UNITS;
          end else begin
            target = 0;
          end
        end
        5:       target = $urandom_range(0, OCTAVE_UNITS - 1);
        default: target = corner_pitch[$urandom_range(0, 5)];
      endcase
      target = clamp_pitch(target);
      queue_request(CMD_ADD, int'(target), rand_pitch());
      scale_notes.insert(scale_notes.size(), fold_octave(int'(target)));
    end
    n_quant = $urandom_range(1, 12);
    repeat (n_quant) begin
      oct = $urandom_range(0, 218);
      oct = oct - 109;
      ofs = $urandom_range(0, 600);
      ofs = ofs - 300;
      k   = $urandom_range(0, 5);
      if (scale_notes.size() == 0 && (k == 1 || k == 2)) k = 0;
      case (k)
        0: target = rand_pitch();
        1: begin
          a      = $urandom_range(0, scale_notes.size() - 1);
          target = longint'(oct) * OCTAVE_UNITS + scale_notes[a] + ofs;
        end
        2: begin
          // Halfway between two notes: equidistant from both whenever the sum is even.
          a      = scale_notes[$urandom_range(0, scale_notes.size() - 1)];
          b      = scale_notes[$urandom_range(0, scale_notes.size() - 1)];
          target = longint'(oct) * OCTAVE_UNITS + (a + b) / 2;
        end
        3: begin
          a      = $urandom_range(0, 80000);
          target = $urandom_range(0, 1) ? PITCH_MAX - a : PITCH_MIN + a;
        end
        4: begin
          a      = $urandom_range(0, 6);
          target = longint'(oct) * OCTAVE_UNITS + a - 3;
        end
        default: begin
          a      = $urandom_range(0, 4 * OCTAVE_UNITS);
          target = a - 2 * OCTAVE_UNITS;
        end
      endcase
      queue_request(CMD_QUANT, rand_pitch(), clamp_pitch(target));
    end
    if ($urandom_range(0, 9) == 0)
      queue_request(CMD_UNUSED, rand_pitch(), rand_pitch());
    if ($urandom_range(0, 19) == 0)
      queue_request(2'($urandom_range(0, 3)), rand_pitch(), rand_pitch());
  endtask

  // Block until every queued request has gone in and every result came out.
  task automatic wait_drained();
    while (request_queue.size() != 0 || awaited_responses.size() != 0)
      @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Sampling at the rising edge: first check any result that leaves the
  // block, then feed any request that enters it into the scoreboard. A result
  // can never belong to a request accepted at the same edge, so the order of
  // the two steps does not matter for correctness.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (awaited_responses.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"ERROR: result with nothing pending: ",
                      "pitch %0d entry %0d shift %0d status %0d count %0d"},
                     out_ch.voltage_out, out_ch.chosen_entry, out_ch.octave_shift,
                     out_ch.status, out_ch.entry_count);
        end else begin
          want = awaited_responses.pop_front();
          if (out_ch.voltage_out !== want.pitch || out_ch.chosen_entry !== want.entry ||
              out_ch.octave_shift !== want.shift || out_ch.status !== want.status ||
              out_ch.entry_count !== want.count) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("ERROR: expected pitch %0d entry %0d shift %0d status %0d count %0d",
                       want.pitch, want.entry, want.shift, want.status, want.count);
              $display("       actual   pitch %0d entry %0d shift %0d status %0d count %0d",
                       out_ch.voltage_out, out_ch.chosen_entry, out_ch.octave_shift,
                       out_ch.status, out_ch.entry_count);
            end
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        compute_response(in_ch.cmd, in_ch.interval_value, in_ch.voltage_in);
        void'(request_queue.pop_front());
      end
      req_taken <= in_ch.valid && in_ch.ready;
    end else begin
      req_taken <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Request driver, at the falling edge. A request once offered stays on the
  // channel until it is taken; between requests the source idles at random
  // according to the current phase.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && !req_taken) begin
      // Still waiting for the block to take the current request.
    end else if (request_queue.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
      in_ch.valid          <= 1'b1;
      in_ch.cmd            <= request_queue[0].cmd;
      in_ch.interval_value <= request_queue[0].interval;
      in_ch.voltage_in     <= request_queue[0].voltage;
    end else begin
      in_ch.valid <= 1'b0;
    end
  end

  // Result acceptor, at the falling edge: random stalls per phase, and a
  // constant stall while a long hold-off is running.
  always @(negedge clk) begin
    out_ch.ready <= rst_n && hold_left == 0 && ($urandom_range(0, 99) >= snk_stall_pct);
  end

  // Long receiver hold-off, counted here in cycles once the main sequence
  // asks for it. The sender keeps offering, so the block has to back up.
  always @(negedge clk) begin
    if (hold_go) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin
    rst_n                = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.cmd            = CMD_CLEAR;
    in_ch.interval_value = '0;
    in_ch.voltage_in     = '0;
    out_ch.ready         = 1'b0;
    hold_go              = 1'b0;
    hold_left            = 0;
    src_idle_pct         = 0;
    snk_stall_pct        = 0;
    note_count           = 0;
    mismatches           = 0;
    ignored_count        = 0;
    phase_count          = 0;
    foreach (status_tally[i]) status_tally[i] = 0;
    foreach (scale_table[i]) scale_table[i] = 0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part, no idling. An empty table passes the extremes through
    // and a clear on it is harmless.
    queue_request(CMD_QUANT, 0, PITCH_MAX);
    queue_request(CMD_QUANT, 0, PITCH_MIN);
    queue_request(CMD_CLEAR, 0, 0);
    // A whole octave folds to unison, so the first add only seeds unison;
    // adding unison again is a duplicate.
    queue_request(CMD_ADD, OCTAVE_UNITS, 0);
    queue_request(CMD_ADD, 0, 0);
    queue_request(CMD_CLEAR, 0, 0);
    // First add of a real interval brings unison in with it.
    queue_request(CMD_ADD, 38400, 0);
    // Equidistant from unison and the tritone: the lower entry wins.
    queue_request(CMD_QUANT, 0, 19200);
    // Negative and extreme intervals fold into the octave.
    queue_request(CMD_ADD, -1, 0);
    queue_request(CMD_ADD, PITCH_MAX, 0);
    queue_request(CMD_ADD, PITCH_MIN, 0);
    queue_request(CMD_ADD, 20000, 0);
    queue_request(CMD_QUANT, 0, 76700);
    queue_request(CMD_CLEAR, 0, 0);
    queue_request(CMD_ADD, 30000, 0);
    // Top of range snaps upward past the limit and saturates high.
    queue_request(CMD_QUANT, 0, PITCH_MAX);
    // Near the top of an octave unison one octave up is closest.
    queue_request(CMD_QUANT, 0, 76000);
    queue_request(CMD_CLEAR, 0, 0);
    queue_request(CMD_ADD, 50000, 0);
    // Bottom of range snaps downward past the limit and saturates low.
    queue_request(CMD_QUANT, 0, PITCH_MIN);
    queue_request(CMD_QUANT, 0, 25000);
    queue_request(CMD_UNUSED, -1, -1);
    queue_request(CMD_QUANT, 0, 0);
    queue_request(CMD_ADD, 50000 - 2 * OCTAVE_UNITS, 0);
    wait_drained();

    // Random phase with no idling, opened by a long receiver hold-off.
    phase_count = 0;
    while (phase_count < PHASE_ITEMS) gen_scale_session();
    hold_go = 1'b1;
    wait (hold_left != 0);
    hold_go = 1'b0;
    wait_drained();

    // Sender mostly idle.
    src_idle_pct = 62;
    phase_count  = 0;
    while (phase_count < PHASE_ITEMS) gen_scale_session();
    wait_drained();

    // Receiver mostly stalling.
    src_idle_pct  = 0;
    snk_stall_pct = 62;
    phase_count   = 0;
    while (phase_count < PHASE_ITEMS) gen_scale_session();
    wait_drained();

    // Both sides idling now and then.
    src_idle_pct  = 19;
    snk_stall_pct = 19;
    phase_count   = 0;
    while (phase_count < PHASE_ITEMS) gen_scale_session();
    wait_drained();

    // Give a late or spurious result the chance to show up.
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d quantized, %0d saturated, %0d passthrough results.",
             status_tally[STAT_QUANT], status_tally[STAT_SAT], status_tally[STAT_PASS]);
    $display({"Table: %0d added, %0d duplicate, %0d full, %0d cleared; ",
              "%0d unused codes; %0d mismatches."},
             status_tally[STAT_ADDED], status_tally[STAT_DUP], status_tally[STAT_FULL],
             status_tally[STAT_CLEARED], ignored_count, mismatches);
    if (mismatches == 0) begin
      $display("scale_pitch_quantizer test passed");
    end else begin
      $display("scale_pitch_quantizer test failed");
    end
    $finish;
  end

endmodule
